// File: hdl/bbft_pkg.sv
package bbft_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int WIN       = 5;
  localparam int HIST_W    = WIN - 1;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = 11;
  localparam int COORD_W   = 11;
  localparam int CFG_W_W   = 12;
  localparam int THR_W     = 5;
  // wide enough for the width register and for MAX_WIDTH itself
  localparam int EW_W      = (COL_W + 1 > CFG_W_W) ? COL_W + 1 : CFG_W_W;
  localparam int CNT_W     = 3;
  localparam int SUM_W     = 5;

  localparam logic [CFG_W_W-1:0] WIDTH_RESET = 12'd1024;
  localparam logic [THR_W-1:0]   THR_RESET   = 5'd10;

  localparam logic CFG_FRAME_WIDTH     = 1'b0;
  localparam logic CFG_COUNT_THRESHOLD = 1'b1;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  typedef struct packed {
    logic             valid;
    logic             emit;
    logic             pix;
    logic             last;
    logic             clr;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } stage_t;

endpackage

// File: hdl/binary_box_filter_threshold_unit.sv
// Binary 5x5 box filter with count threshold, one pixel per clock while the output is not stalled.
// Pipeline: an accepted pixel passes through the s1 stage register, then the output register.
// Throughput: 1 pixel per cycle unless the output stalls, set by the column history RAM read-modify-write per column.
// Reset: synchronous, clears counters, window column cells and config to defaults.
// The column history RAM is not cleared; no clearing pass, no wait after reset.
module binary_box_filter_threshold_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] pixel_bit, [7:1] zero
  input  logic        s_axis_tuser,   // [0] frame_start
  input  logic        s_axis_tlast,   // frame_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [0] clean_pixel, [5:1] window_count,
                                      // [16:6] center_row, [27:17] center_col, [31:28] zero
  output logic        m_axis_tlast,   // last_of_frame
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);
  import bbft_pkg::*;

  logic [CFG_W_W-1:0] frame_width;
  logic [THR_W-1:0]   count_threshold;
  logic [ROW_W-1:0]   row_counter;
  logic [COL_W-1:0]   col_counter;
  logic               restart_pend;
  stage_t             s1;
  logic               lw_valid;
  logic [COL_W-1:0]   lw_addr;
  logic [HIST_W-1:0]  lw_data;

  logic               en;
  logic               accept;
  logic [EW_W-1:0]    eff_width;
  logic [COL_W-1:0]   col_c;
  logic [COL_W-1:0]   col_a;
  logic [ROW_W-1:0]   row_a;
  logic [EW_W-1:0]    col_inc;
  logic               col_wrap;
  logic [HIST_W-1:0]  ram_rdata;
  logic [HIST_W-1:0]  hist;
  logic [CNT_W-1:0]   new_count;
  logic               we;
  logic [SUM_W-1:0]   total;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= WIDTH_RESET;
      count_threshold <= THR_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:     frame_width     <= cfg_data;
        CFG_COUNT_THRESHOLD: count_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;

  always_comb begin
    eff_width = EW_W'(frame_width);
    if (eff_width < EW_W'(WIN)) begin
      eff_width = EW_W'(WIN);
    end
    if (eff_width > EW_W'(MAX_WIDTH)) begin
      eff_width = EW_W'(MAX_WIDTH);
    end
    col_c    = s_axis_tuser ? '0 : col_counter;
    row_a    = s_axis_tuser ? '0 : row_counter;
    col_a    = (EW_W'(col_c) >= eff_width) ? '0 : col_c;
    col_inc  = EW_W'(col_a) + EW_W'(1);
    col_wrap = col_inc >= eff_width;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_counter  <= '0;
      col_counter  <= '0;
      restart_pend <= 1'b0;
    end else if (accept) begin
      restart_pend <= s_axis_tlast || col_wrap;
      if (s_axis_tlast) begin
        row_counter <= '0;
        col_counter <= '0;
      end else if (col_wrap) begin
        row_counter <= row_a + ROW_W'(1);
        col_counter <= '0;
      end else begin
        row_counter <= row_a;
        col_counter <= col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (en) begin
      s1.valid <= s_axis_tvalid;
    end
    if (en) begin
      s1.emit <= (row_a >= ROW_W'(WIN - 1)) && (col_a >= COL_W'(WIN - 1));
      s1.pix  <= s_axis_tdata[0];
      s1.last <= s_axis_tlast;
      s1.clr  <= s_axis_tuser || restart_pend;
      s1.col  <= col_a;
      s1.row  <= row_a;
    end
  end

  assign we = en && s1.valid;

  bbft_ram #(
    .WIDTH(HIST_W),
    .DEPTH(MAX_WIDTH)
  ) u_hist (
    .clk  (clk),
    .we   (we),
    .waddr(s1.col),
    .wdata({hist[HIST_W-2:0], s1.pix}),
    .re   (en),
    .raddr(col_a),
    .rdata(ram_rdata)
  );

  // the previous pixel's write lands in the same cycle as this pixel's read
  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else if (we) begin
      lw_valid <= 1'b1;
    end
    if (we) begin
      lw_addr <= s1.col;
      lw_data <= {hist[HIST_W-2:0], s1.pix};
    end
  end

  always_comb begin
    hist = (lw_valid && lw_addr == s1.col) ? lw_data : ram_rdata;
    new_count = CNT_W'(s1.pix);
    for (int k = 0; k < HIST_W; k++) begin
      new_count = new_count + CNT_W'(hist[k]);
    end
  end

  // window column counts: newest enters the last cell, oldest drops off cell 0
  logic [CNT_W-1:0] chain [WIN+1];
  logic [SUM_W-1:0] psum  [WIN+1];

  assign chain[WIN] = new_count;
  assign psum[0]    = '0;

  for (genvar k = 0; k < WIN; k++) begin : g_cell
    cell_ctl_t ctl;
    assign ctl.shift = we;
    assign ctl.clear = s1.clr && (k < WIN - 1);
    bbft_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .shift_in (chain[k+1]),
      .shift_out(chain[k]),
      .psum_in  (psum[k]),
      .psum_out (psum[k+1])
    );
  end

  assign total = psum[WIN];

  logic               out_clean;
  logic [SUM_W-1:0]   out_count;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= s1.valid && s1.emit;
    end
    if (en) begin
      out_clean    <= total > count_threshold;
      out_count    <= total;
      out_row      <= COORD_W'(s1.row - ROW_W'(2));
      out_col      <= COORD_W'(s1.col - COL_W'(2));
      m_axis_tlast <= s1.last;
    end
  end

  // chain[0] is the oldest column leaving the window
  logic unused_oldest;
  assign unused_oldest = ^chain[0];

  assign m_axis_tdata = {3'b000, unused_oldest & 1'b0, out_col, out_row, out_count, out_clean};

endmodule

// File: hdl/bbft_ram.sv
module bbft_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/bbft_cell.sv
module bbft_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  bbft_pkg::cell_ctl_t       ctl,
  input  logic [bbft_pkg::CNT_W-1:0] shift_in,
  output logic [bbft_pkg::CNT_W-1:0] shift_out,
  input  logic [bbft_pkg::SUM_W-1:0] psum_in,
  output logic [bbft_pkg::SUM_W-1:0] psum_out
);
  import bbft_pkg::*;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  always_comb begin
    count_next = count;
    if (ctl.shift) begin
      count_next = ctl.clear ? '0 : shift_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  assign shift_out = count;
  // running sum sees the updated column count
  assign psum_out  = psum_in + SUM_W'(count_next);

endmodule

// File: tb/sv/binary_box_filter_threshold_unit_test.sv
module binary_box_filter_threshold_unit_test;
  import bbft_pkg::*;

  localparam int CYCLE_LIMIT  = 400_000;
  localparam int RANDOM_ITEMS = 1250;

  typedef struct packed {
    logic        clean;
    logic [4:0]  count;
    logic [10:0] crow;
    logic [10:0] ccol;
    logic        eof;
  } filt_res_t;

  typedef struct packed {
    logic      pix;
    logic      start;
    logic      stop;
    logic      known;
    filt_res_t res;
  } plan_row_t;

  typedef enum int {IDLE_RANDOM, IDLE_SPARSE, IDLE_NONE} idle_mode_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [0] pixel_bit, [7:1] zero
  logic        s_axis_tuser;   // [0] frame_start
  logic        s_axis_tlast;   // frame_end
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [0] clean_pixel, [5:1] window_count,
                               // [16:6] center_row, [27:17] center_col, [31:28] zero
  logic        m_axis_tlast;   // last_of_frame
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [11:0] cfg_data;

  binary_box_filter_threshold_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #6 clk = ~clk;

  // Filter model state
  logic [3:0]  col_bits [0:MAX_WIDTH-1];
  int          col_sums [0:WIN-1];
  logic [10:0] row_pos;
  logic [10:0] col_pos;
  logic [11:0] width_reg;
  logic [4:0]  thresh_reg;

  filt_res_t   pending_results [$];
  idle_mode_t  idle_mode = IDLE_RANDOM;
  bit          hold_output = 1'b0;
  int          pixels_sent = 0;
  int          frames_sent = 0;
  int          results_checked = 0;
  int          mismatches = 0;
  int          cycle_count = 0;

  // 0 + first/last row: all ones 5x5 frame, width 0 clamps to 5, threshold 24
  plan_row_t directed_plan [0:24] = '{
    '{1'b1, 1'b1, 1'b0, 1'b0, '0}, '{1'b1, 1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, 1'b0, '0}, '{1'b1, 1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, 1'b0, '0}, '{1'b1, 1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, 1'b0, '0}, '{1'b1, 1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, 1'b0, '0}, '{1'b1, 1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, 1'b0, '0}, '{1'b1, 1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, 1'b0, '0}, '{1'b1, 1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, 1'b0, '0}, '{1'b1, 1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, 1'b0, '0}, '{1'b1, 1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, 1'b0, '0}, '{1'b1, 1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, 1'b0, '0}, '{1'b1, 1'b0, 1'b0, 1'b0, '0},
    '{1'b1, 1'b0, 1'b0, 1'b0, '0}, '{1'b1, 1'b0, 1'b0, 1'b0, '0},
    // full window in the last pixel: count 25 centered at (2,2)
    '{1'b1, 1'b0, 1'b1, 1'b1, '{1'b1, 5'd25, 11'd2, 11'd2, 1'b1}}
  };

  function automatic int eff_width();
    int w;
    w = width_reg;
    if (w < WIN) w = WIN;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  task automatic restart_frame();
    row_pos = '0;
    col_pos = '0;
    foreach (col_sums[k]) col_sums[k] = 0;
  endtask

  task automatic reset_filter_model();
    foreach (col_bits[k]) col_bits[k] = '0;
    restart_frame();
    width_reg  = 12'd1024;
    thresh_reg = 5'd10;
  endtask

  // Advance the window by one pixel; returns the result for the window center if any.
  task automatic filter_pixel(input logic pix, input logic start, input logic stop,
                              output bit produced, output filt_res_t r);
    int         w;
    int         c;
    int         sum;
    logic [3:0] h;
    if (start) restart_frame();
    w = eff_width();
    c = col_pos;
    if (c >= w) c = 0;
    h = col_bits[c];
    for (int k = 0; k < WIN - 1; k++) col_sums[k] = col_sums[k + 1];
    col_sums[WIN-1] = $countones(h) + pix;
    col_bits[c] = {h[2:0], pix};
    sum = 0;
    foreach (col_sums[k]) sum += col_sums[k];
    produced = (row_pos >= WIN - 1) && (c >= WIN - 1);
    r.clean  = (sum > thresh_reg);
    r.count  = sum[4:0];
    r.crow   = row_pos - 11'd2;
    r.ccol   = 11'(c - 2);
    r.eof    = stop;
    if (stop) begin
      restart_frame();
    end else begin
      c++;
      if (c >= w) begin
        c = 0;
        row_pos = row_pos + 11'd1;
        foreach (col_sums[k]) col_sums[k] = 0;
      end
      col_pos = 11'(c);
    end
  endtask

  function automatic int pick_gap();
    case (idle_mode)
      IDLE_NONE:   return 0;
      IDLE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16) : 0;
      default:     return $urandom_range(0, 16);
    endcase
  endfunction

  task automatic write_reg(input logic idx, input logic [11:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_FRAME_WIDTH) width_reg = val;
    else thresh_reg = val[4:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Valid is left high after a request so back-to-back pixels need no toggle.
  task automatic send_pixel(input logic pix, input logic start, input logic stop,
                            input logic known, input filt_res_t typed);
    int        gap;
    bit        produced;
    filt_res_t r;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, pix};
    s_axis_tuser  <= start;
    s_axis_tlast  <= stop;
    do @(posedge clk); while (!s_axis_tready);
    pixels_sent++;
    filter_pixel(pix, start, stop, produced, r);
    if (known) pending_results = {pending_results, typed};
    else if (produced) pending_results = {pending_results, r};
  endtask

  task automatic send_frame(input int rows, input int tail, input int density,
                            input bit broken);
    int n;
    n = rows * eff_width() + tail;
    if (n < 1) n = 1;
    frames_sent++;
    for (int i = 0; i < n; i++) begin
      logic pix;
      logic start;
      logic stop;
      pix   = ($urandom_range(1, 100) <= density);
      start = (i == 0);
      stop  = (i == n - 1);
      if (broken) begin
        // stray frame markers and dropped starts
        start = ($urandom_range(0, 29) == 0) || (start && $urandom_range(0, 1));
        stop  = ($urandom_range(0, 29) == 0) || stop;
      end
      send_pixel(pix, start, stop, 1'b0, '0);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Output side: random stalls per result, plus one long hold-off on request.
  initial begin
    forever begin
      int stall;
      @(negedge clk);
      if (hold_output) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_output = 1'b0;
      end
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk) begin
    filt_res_t got;
    filt_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[0], m_axis_tdata[5:1], m_axis_tdata[16:6],
              m_axis_tdata[27:17], m_axis_tlast};
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected result clean=%0d count=%0d row=%0d col=%0d last=%0d",
                   $realtime, got.clean, got.count, got.crow, got.ccol, got.eof);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.clean !== want.clean || got.count !== want.count ||
            got.crow !== want.crow || got.ccol !== want.ccol || got.eof !== want.eof) begin
          if (mismatches < 10) begin
            $display("%0t: mismatch expected clean=%0d count=%0d row=%0d col=%0d last=%0d",
                     $realtime, want.clean, want.count, want.crow, want.ccol, want.eof);
            $display("%0t:          got      clean=%0d count=%0d row=%0d col=%0d last=%0d",
                     $realtime, got.clean, got.count, got.crow, got.ccol, got.eof);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int random_start;
    int density;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_FRAME_WIDTH;
    cfg_data      = '0;
    reset_filter_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: smallest frame, clamped width
    write_reg(CFG_FRAME_WIDTH, 12'd0);
    write_reg(CFG_COUNT_THRESHOLD, 12'd24);
    frames_sent++;
    foreach (directed_plan[i])
      send_pixel(directed_plan[i].pix, directed_plan[i].start, directed_plan[i].stop,
                 directed_plan[i].known, directed_plan[i].res);
    wait_drained();

    // width above max clamps; one partial row gives no result
    write_reg(CFG_FRAME_WIDTH, 12'd4095);
    write_reg(CFG_COUNT_THRESHOLD, 12'd0);
    idle_mode = IDLE_NONE;
    send_frame(0, 150, 50, 1'b0);
    wait_drained();

    // output held off while input keeps coming
    write_reg(CFG_FRAME_WIDTH, 12'd12);
    hold_output = 1'b1;
    send_frame(8, 0, 50, 1'b0);
    wait_drained();

    // narrow frame, threshold above any count
    write_reg(CFG_FRAME_WIDTH, 12'd5);
    write_reg(CFG_COUNT_THRESHOLD, 12'd26);
    idle_mode = IDLE_SPARSE;
    send_frame(10, 3, 85, 1'b0);
    wait_drained();

    write_reg(CFG_COUNT_THRESHOLD, 12'd31);
    idle_mode = IDLE_RANDOM;
    send_frame(5, 2, 100, 1'b0);
    wait_drained();

    random_start = pixels_sent;
    while (pixels_sent - random_start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       write_reg(CFG_FRAME_WIDTH, 12'($urandom_range(0, 4)));
        1:       write_reg(CFG_FRAME_WIDTH, 12'($urandom_range(13, 40)));
        default: write_reg(CFG_FRAME_WIDTH, 12'($urandom_range(5, 12)));
      endcase
      write_reg(CFG_COUNT_THRESHOLD, 12'($urandom_range(0, 31)));
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 5))
          0:       idle_mode = IDLE_NONE;
          1:       idle_mode = IDLE_SPARSE;
          default: idle_mode = IDLE_RANDOM;
        endcase
        case ($urandom_range(0, 5))
          0:       density = 0;
          1:       density = 100;
          default: density = $urandom_range(0, 100);
        endcase
        send_frame($urandom_range(1, 8), $urandom_range(0, eff_width() - 1), density,
                   ($urandom_range(0, 4) == 0));
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("%0d pixels in %0d frames, %0d results checked, %0d mismatches",
             pixels_sent, frames_sent, results_checked, mismatches);
    $display("widths 0..4095 with clamping, long output hold-off, broken frame markers, "
             , "thresholds 0..31");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/bbft_pkg.sv
hdl/bbft_ram.sv
hdl/bbft_cell.sv
hdl/binary_box_filter_threshold_unit.sv
tb/sv/binary_box_filter_threshold_unit_test.sv
